### design/ssct_pkg.sv
// ----------------------------------------------------------------------------
// ssct_pkg: shared constants for the singly charged spectrum test
// Field widths, register indexes and the arithmetic constants that the top
// level and its port checker both use.
// ----------------------------------------------------------------------------
package ssct_pkg;

  localparam int MASS_W      = 24;
  localparam int INTEN_W     = 32;
  localparam int SUM_W       = 48;
  // 5 * sum (51 bits) times a 24-bit mass, with headroom
  localparam int ALU_W       = 76;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 8;
  localparam int MUL_STEPS   = MASS_W;
  localparam int CNT_W       = $clog2(MUL_STEPS);

  // 20 Th window in 1/1024 Th units
  localparam logic [MASS_W:0]  WIN_LSB = 25'd20480;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRECURSOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MASS = 1'd1;

endpackage

### design/spectrum_singly_charged_test.sv
// ----------------------------------------------------------------------------
// spectrum_singly_charged_test: charge state hint from one spectrum
// Streams the peaks of a spectrum, sums intensity below and above the
// precursor window, and on the last peak returns a singly charged hint.
// ----------------------------------------------------------------------------
// Peaks arrive in ascending m/z order, one per transfer, with tlast on the
// final peak; each transfer is one peak and a spectrum needs at least one.
// Every arithmetic step (window compares, saturating sums, the 5x product,
// the two shift-add multiplies and the final compare) runs through a single
// 76-bit add/subtract unit under a small sequencer, so the input side takes
// one peak at a time: a non-last peak passes through the transfer and four
// adder steps, and the last peak goes on to the decision steps, the long case
// being two 24-step multiplies when 2*precursor >= high mass. The result
// (tdata bit 0: 1 = singly charged, 0 = try charges 2 and 3) sits in an
// output register, so a new spectrum can start while it waits. Write
// precursor_mz (index 0) and high_mass (index 1) only while the block is idle.
// ----------------------------------------------------------------------------
module spectrum_singly_charged_test (
  input  logic                                 clk,
  input  logic                                 rst,
  // peak stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [23:0] peak_mass, [55:24] peak_intensity
  input  logic [ssct_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                 s_axis_tlast,   // last_peak
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] charge_hint, [7:1] zero
  output logic [ssct_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ssct_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ssct_pkg::MASS_W-1:0]          cfg_data
);

  localparam int MW = ssct_pkg::MASS_W;
  localparam int IW = ssct_pkg::INTEN_W;
  localparam int SW = ssct_pkg::SUM_W;
  localparam int AW = ssct_pkg::ALU_W;
  localparam int CW = ssct_pkg::CNT_W;

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LO   = 4'd1;   // mass + 20 Th >= precursor
  localparam logic [3:0] S_HI   = 4'd2;   // mass >= precursor + 20 Th
  localparam logic [3:0] S_BSUM = 4'd3;   // left sum update
  localparam logic [3:0] S_ASUM = 4'd4;   // right sum update
  localparam logic [3:0] S_D5   = 4'd5;   // 5 * right sum
  localparam logic [3:0] S_D2P  = 4'd6;   // 2P against H
  localparam logic [3:0] S_D5C  = 4'd7;   // 5 * right < left
  localparam logic [3:0] S_DHP  = 4'd8;   // H - P
  localparam logic [3:0] S_MUL  = 4'd9;   // shift-add multiply
  localparam logic [3:0] S_CMPW = 4'd10;  // wide product compare
  localparam logic [3:0] S_DONE = 4'd11;  // hand result to output register

  logic [3:0]    state;

  // configuration
  logic [MW-1:0] precursor_mz;
  logic [MW-1:0] high_mass;

  // captured peak
  logic [MW-1:0] peak_mass;
  logic [IW-1:0] peak_intensity;
  logic          last_peak;

  // spectrum state
  logic [SW-1:0] below_sum;
  logic [SW-1:0] above_sum;
  logic          below_closed;
  logic          above_opened;
  logic          first_peak_pending;
  logic          add_below;
  logic          add_above;

  // decision datapath
  logic [AW-1:0] tmp;        // 5 * right sum, then 5 * right * P
  logic [AW-1:0] acc;
  logic [AW-1:0] mcand;
  logic [MW-1:0] mplier;
  logic [MW-1:0] hp;
  logic [CW-1:0] cnt;
  logic          phase;      // 0: 5*right*P, 1: left*(H-P)
  logic          res;

  // output register
  logic          out_valid;
  logic          charge_hint;
  logic          load_out;

  // shared adder
  logic [AW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  logic          alu_sub;
  logic [AW:0]   alu_sum;
  logic          alu_carry;
  logic [SW-1:0] sat_sum;
  logic [MW:0]   mass_win;
  logic [MW:0]   prec_win;

  assign mass_win = {1'b0, peak_mass} + ssct_pkg::WIN_LSB;
  assign prec_win = {1'b0, precursor_mz} + ssct_pkg::WIN_LSB;

  // Route operands for the step at hand. For a subtract the carry out is
  // the a >= b flag.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_LO: begin
        alu_a   = AW'(mass_win);
        alu_b   = AW'(precursor_mz);
        alu_sub = 1'b1;
      end
      S_HI: begin
        alu_a   = AW'(peak_mass);
        alu_b   = AW'(prec_win);
        alu_sub = 1'b1;
      end
      S_BSUM: begin
        alu_a = AW'(below_sum);
        alu_b = AW'(peak_intensity);
      end
      S_ASUM: begin
        alu_a = AW'(above_sum);
        alu_b = AW'(peak_intensity);
      end
      S_D5: begin
        alu_a = AW'({above_sum, 2'b00});
        alu_b = AW'(above_sum);
      end
      S_D2P: begin
        alu_a   = AW'({precursor_mz, 1'b0});
        alu_b   = AW'(high_mass);
        alu_sub = 1'b1;
      end
      S_D5C: begin
        alu_a   = tmp;
        alu_b   = AW'(below_sum);
        alu_sub = 1'b1;
      end
      S_DHP: begin
        alu_a   = AW'(high_mass);
        alu_b   = AW'(precursor_mz);
        alu_sub = 1'b1;
      end
      S_MUL: begin
        alu_a = acc;
        alu_b = mplier[0] ? mcand : '0;
      end
      S_CMPW: begin
        alu_a   = tmp;
        alu_b   = acc;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + {{AW{1'b0}}, alu_sub};
  assign alu_carry = alu_sum[AW];
  // clamp a sum that ran past the 48-bit range
  assign sat_sum   = (|alu_sum[AW:SW]) ? ssct_pkg::SUM_MAX : alu_sum[SW-1:0];

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(ssct_pkg::OUT_TDATA_W-1){1'b0}}, charge_hint};

  // load a finished result only when the output register is free
  assign load_out = (state == S_DONE) && (!out_valid || m_axis_tready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      precursor_mz <= '0;
      high_mass    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ssct_pkg::CFG_PRECURSOR: precursor_mz <= cfg_data;
        ssct_pkg::CFG_HIGH_MASS: high_mass    <= cfg_data;
        default: ;
      endcase
    end
  end

  // output valid: set on a load, drop once the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      below_sum          <= SW'(1);
      above_sum          <= SW'(1);
      below_closed       <= 1'b0;
      above_opened       <= 1'b0;
      first_peak_pending <= 1'b1;
      add_below          <= 1'b0;
      add_above          <= 1'b0;
      phase              <= 1'b0;
      cnt                <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            peak_mass      <= s_axis_tdata[MW-1:0];
            peak_intensity <= s_axis_tdata[MW+IW-1:MW];
            last_peak      <= s_axis_tlast;
            state          <= S_LO;
          end
        end
        S_LO: begin
          add_below <= !below_closed && !alu_carry;
          if (!below_closed && alu_carry) begin
            below_closed <= 1'b1;
          end
          state <= S_HI;
        end
        S_HI: begin
          // the very first peak opens the window without counting
          add_above <= above_opened || (alu_carry && !first_peak_pending);
          if (!above_opened && alu_carry) begin
            above_opened <= 1'b1;
          end
          state <= S_BSUM;
        end
        S_BSUM: begin
          if (add_below) begin
            below_sum <= sat_sum;
          end
          state <= S_ASUM;
        end
        S_ASUM: begin
          if (add_above) begin
            above_sum <= sat_sum;
          end
          first_peak_pending <= 1'b0;
          if (!last_peak) begin
            state <= S_IDLE;
          end else if (!above_opened) begin
            // no peak reached the upper window
            res   <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_D5;
          end
        end
        S_D5: begin
          tmp   <= alu_sum[AW-1:0];
          state <= S_D2P;
        end
        S_D2P: begin
          state <= alu_carry ? S_DHP : S_D5C;
        end
        S_D5C: begin
          res   <= !alu_carry;
          state <= S_DONE;
        end
        S_DHP: begin
          if (!alu_carry || (alu_sum[MW-1:0] == '0)) begin
            // high mass not above the precursor
            res   <= 1'b0;
            state <= S_DONE;
          end else begin
            hp     <= alu_sum[MW-1:0];
            acc    <= '0;
            mcand  <= tmp;
            mplier <= precursor_mz;
            cnt    <= '0;
            phase  <= 1'b0;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          if (cnt == CW'(ssct_pkg::MUL_STEPS - 1)) begin
            cnt <= '0;
            if (!phase) begin
              // hold 5 * right * P, start left sum times (H - P)
              tmp    <= alu_sum[AW-1:0];
              acc    <= '0;
              mcand  <= AW'(below_sum);
              mplier <= hp;
              phase  <= 1'b1;
            end else begin
              acc   <= alu_sum[AW-1:0];
              state <= S_CMPW;
            end
          end else begin
            acc    <= alu_sum[AW-1:0];
            mcand  <= {mcand[AW-2:0], 1'b0};
            mplier <= {1'b0, mplier[MW-1:1]};
            cnt    <= cnt + CW'(1);
          end
        end
        S_CMPW: begin
          res   <= !alu_carry;
          state <= S_DONE;
        end
        S_DONE: begin
          // advance only when the output register is free
          if (load_out) begin
            charge_hint        <= res;
            below_sum          <= SW'(1);
            above_sum          <= SW'(1);
            below_closed       <= 1'b0;
            above_opened       <= 1'b0;
            first_peak_pending <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/ssct_checker.sv
// ----------------------------------------------------------------------------
// ssct_checker: port-level checks for the singly charged spectrum test
// Watches the top level's ports and flags handshake or sequencing slips.
// ----------------------------------------------------------------------------
module ssct_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [ssct_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [ssct_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [ssct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [ssct_pkg::MASS_W-1:0]      cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  // only the hint bit is ever set
  a_out_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[ssct_pkg::OUT_TDATA_W-1:1] == '0))
    else $error("result padding bits not zero");

  // one peak at a time: busy right after a transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("peak accepted while busy");

  // a non-last peak returns the input side after its four adder steps
  a_peak_len: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast |-> ##5 s_axis_tready)
    else $error("non-last peak did not finish in time");

endmodule

bind spectrum_singly_charged_test ssct_checker u_ssct_checker (.*);
